// ----- hw/rtl/ddh_pkg.sv -----
package ddh_pkg;

	// Fixed field widths of the stream and configuration ports.
	localparam int ADDR_W  = 16;
	localparam int VALUE_W = 8;
	localparam int CFG_W   = 9;

	// Level arithmetic: a level is signed, in units of 1/(255*256) of white.
	localparam int LEVEL_W = 18;
	// Numerator of one diffusion share: error * 2 * weight.
	localparam int NUM_W   = LEVEL_W + 1 + VALUE_W;
	// Weight sum, wide enough for a 7x7 kernel of full weights.
	localparam int WT_W    = 14;

	localparam logic signed [LEVEL_W-1:0] LVL_HALF = 18'sd32640;
	localparam logic signed [LEVEL_W-1:0] LVL_ONE  = 18'sd65280;
	localparam logic signed [LEVEL_W-1:0] LVL_MAX  = 18'sd131071;
	localparam logic signed [LEVEL_W-1:0] LVL_MIN  = -18'sd131072;
	localparam logic [VALUE_W-1:0]        DOT_ON   = 8'hFF;
	localparam logic [VALUE_W-1:0]        DOT_OFF  = 8'h00;

	typedef enum logic [1:0] {
		OP_CLASS  = 2'd0,
		OP_WEIGHT = 2'd1,
		OP_PIXEL  = 2'd2,
		OP_READ   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		CFG_IMAGE_WIDTH  = 2'd0,
		CFG_IMAGE_HEIGHT = 2'd1,
		CFG_CLASS_WIDTH  = 2'd2,
		CFG_CLASS_HEIGHT = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		op_t                op;
		logic [ADDR_W-1:0]  address;
		logic [VALUE_W-1:0] value;
		logic               last;
	} cmd_t;

	typedef struct packed {
		logic [CFG_W-1:0]   image_width;
		logic [CFG_W-1:0]   image_height;
		logic [VALUE_W-1:0] class_width;
		logic [VALUE_W-1:0] class_height;
	} cfg_t;

	typedef struct packed {
		logic               valid;
		logic [ADDR_W-1:0]  address;
		logic [VALUE_W-1:0] level;
	} rsp_t;

	typedef struct packed {
		logic                    start;
		logic signed [NUM_W-1:0] num;
		logic [WT_W-1:0]         den;
	} div_req_t;

	typedef struct packed {
		logic                    done;
		logic signed [NUM_W-1:0] quot;
	} div_rsp_t;

endpackage

// ----- hw/rtl/ddh_ram.sv -----
module ddh_ram import ddh_pkg::*; #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DATA_W-1:0]        wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hw/rtl/ddh_div.sv -----
module ddh_div import ddh_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int MAG_W = NUM_W - 1;
	localparam int CNT_W = $clog2(MAG_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [WT_W-1:0]  rem_q;
	logic [MAG_W-1:0] qmag_q;
	logic [WT_W-1:0]  den_q;
	logic             neg_q;

	logic [MAG_W-1:0]   num_mag;
	logic [WT_W:0]      trial;
	logic               ge;
	logic               last_step;
	logic signed [NUM_W-1:0] q_pos;

	// Magnitude of the numerator; the quotient is truncated toward zero.
	assign num_mag   = req.num[NUM_W-1] ? MAG_W'(-req.num) : MAG_W'(req.num);
	// One restoring step: bring down one dividend bit and try the subtraction.
	assign trial     = {rem_q, qmag_q[MAG_W-1]};
	assign ge        = trial >= {1'b0, den_q};
	assign last_step = busy_q && (cnt_q == CNT_W'(MAG_W - 1));

	// Step counter and handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= last_step;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (last_step) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Remainder and quotient shift register.
	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			rem_q  <= '0;
			qmag_q <= num_mag;
			den_q  <= req.den;
			neg_q  <= req.num[NUM_W-1];
		end else if (busy_q) begin
			rem_q  <= ge ? WT_W'(trial - {1'b0, den_q}) : WT_W'(trial);
			qmag_q <= {qmag_q[MAG_W-2:0], ge};
		end
	end

	assign q_pos    = {1'b0, qmag_q};
	assign rsp.done = done_q;
	assign rsp.quot = neg_q ? -q_pos : q_pos;

endmodule

// ----- hw/rtl/ddh_ctrl.sv -----
module ddh_ctrl import ddh_pkg::*; #(
	parameter int MAX_SIDE       = 256,
	parameter int MAX_CLASS_SIDE = 128,
	parameter int KERNEL_SIDE    = 5,
	parameter int CLASS_COUNT    = 256
) (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t cmd,
	input  logic cmd_valid,
	output logic cmd_ready,
	input  cfg_t cfg,
	output rsp_t rsp,
	input  logic rsp_ready
);

	localparam int PIX_CELLS = MAX_SIDE * MAX_SIDE;
	localparam int PIX_AW    = $clog2(PIX_CELLS);
	localparam int CLS_CELLS = MAX_CLASS_SIDE * MAX_CLASS_SIDE;
	localparam int CLS_AW    = $clog2(CLS_CELLS);
	localparam int K_CELLS   = KERNEL_SIDE * KERNEL_SIDE;
	localparam int K_AW      = $clog2(K_CELLS);
	localparam int HALF      = (KERNEL_SIDE - 1) / 2;
	localparam int XW        = $clog2(MAX_SIDE);
	localparam int DW        = XW + 1;
	localparam int CXW       = $clog2(MAX_CLASS_SIDE);
	localparam int CDW       = CXW + 1;
	localparam int KW        = $clog2(KERNEL_SIDE);
	localparam int PASS_W    = $clog2(CLASS_COUNT);
	localparam int SUM_W     = NUM_W + 1;

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_READ   = 8'b0000_0010,
		ST_CLEAR  = 8'b0000_0100,
		ST_CENTER = 8'b0000_1000,
		ST_CHECK  = 8'b0001_0000,
		ST_NBADDR = 8'b0010_0000,
		ST_NBCHK  = 8'b0100_0000,
		ST_NBDIV  = 8'b1000_0000
	} state_t;

	function automatic logic [DW-1:0] clamp_side(logic [CFG_W-1:0] v);
		logic [DW-1:0] r;
		if (v == '0) begin
			r = DW'(1);
		end else if (32'(v) > MAX_SIDE) begin
			r = DW'(MAX_SIDE);
		end else begin
			r = DW'(v);
		end
		return r;
	endfunction

	function automatic logic [CDW-1:0] clamp_class(logic [VALUE_W-1:0] v);
		logic [CDW-1:0] r;
		if (v == '0) begin
			r = CDW'(1);
		end else if (32'(v) > MAX_CLASS_SIDE) begin
			r = CDW'(MAX_CLASS_SIDE);
		end else begin
			r = CDW'(v);
		end
		return r;
	endfunction

	// Next tile coordinate, wrapping at the tile side.
	function automatic logic [CXW-1:0] wrap_inc(logic [CXW-1:0] v, logic [CDW-1:0] m);
		logic [CXW-1:0] r;
		if ({1'b0, v} + CDW'(1) == m) begin
			r = '0;
		end else begin
			r = v + CXW'(1);
		end
		return r;
	endfunction

	state_t state_q, state_d;

	logic [PASS_W-1:0] pass_q;
	logic [XW-1:0]     x_q, y_q;
	logic [PIX_AW-1:0] pix_q;
	logic [CXW-1:0]    cxh_q [HALF+1];
	logic [CXW-1:0]    cyh_q [HALF+1];
	logic [KW-1:0]     kx_q, ky_q;
	logic [CXW-1:0]    nmx_q, nmy_q;
	logic [PIX_AW-1:0] clr_q;
	logic [WT_W-1:0]   wsum_q;
	logic              dots_ok_q;
	logic              start_q;

	logic [K_AW-1:0]           widx_q;
	logic [PIX_AW-1:0]         nat_q;
	logic signed [LEVEL_W-1:0] err_q;
	logic signed [LEVEL_W-1:0] lvl_q;
	logic signed [NUM_W-1:0]   num_q;
	logic [ADDR_W-1:0]         rd_addr_q;
	logic                      rd_inr_q;
	logic [VALUE_W-1:0]        kern_q [K_CELLS];

	logic [DW-1:0]  w_c, h_c;
	logic [CDW-1:0] cw_c, ch_c;
	logic           acc;
	logic [31:0]    a32;
	logic           x_last, y_last, pass_last, kx_last, ky_last;
	logic [31:0]    nx_off, ny_off, nx, ny;
	logic           nx_lo, ny_lo, in_frame;
	logic [CXW-1:0] nmx_start, nmy_start;
	logic [31:0]    ctr_cls_addr, nb_cls_addr, nb_lvl_addr;
	logic [K_AW-1:0]    kern_idx;
	logic [VALUE_W-1:0] kern_rd;

	logic               cls_we, cls_re, lvl_we, lvl_re, dot_we, dot_re;
	logic [CLS_AW-1:0]  cls_waddr, cls_raddr;
	logic [PIX_AW-1:0]  lvl_waddr, lvl_raddr, dot_waddr, dot_raddr;
	logic [LEVEL_W-1:0] lvl_wdata, lvl_rd;
	logic [VALUE_W-1:0] cls_rd;
	logic               dot_wdata, dot_rd;

	logic                      cls_hit, nb_hit, lvl_over;
	logic signed [LEVEL_W-1:0] lvl_c, err_c, sat_c;
	logic signed [NUM_W-1:0]   prod_c;
	logic signed [SUM_W-1:0]   sum_c;
	logic                      nb_adv, nb_end, px_adv, run_end, nb_start, clr_done;
	state_t                    after_nb;

	div_req_t div_req;
	div_rsp_t div_rsp;

	// Clamped frame and tile sizes.
	assign w_c  = clamp_side(cfg.image_width);
	assign h_c  = clamp_side(cfg.image_height);
	assign cw_c = clamp_class(cfg.class_width);
	assign ch_c = clamp_class(cfg.class_height);

	assign cmd_ready = (state_q == ST_IDLE);
	assign acc       = cmd_valid && cmd_ready;
	assign a32       = 32'(cmd.address);

	// Scan position and neighbour geometry.
	assign x_last    = ({1'b0, x_q} == w_c - DW'(1));
	assign y_last    = ({1'b0, y_q} == h_c - DW'(1));
	assign pass_last = (pass_q == PASS_W'(CLASS_COUNT - 1));
	assign kx_last   = (kx_q == KW'(KERNEL_SIDE - 1));
	assign ky_last   = (ky_q == KW'(KERNEL_SIDE - 1));
	assign nx_off    = 32'(x_q) + 32'(kx_q);
	assign ny_off    = 32'(y_q) + 32'(ky_q);
	assign nx        = nx_off - 32'(HALF);
	assign ny        = ny_off - 32'(HALF);
	assign nx_lo     = nx_off >= 32'(HALF);
	assign ny_lo     = ny_off >= 32'(HALF);
	assign in_frame  = nx_lo && ny_lo && (nx < 32'(w_c)) && (ny < 32'(h_c));
	assign nmx_start = (32'(x_q) >= 32'(HALF)) ? cxh_q[HALF] : '0;
	assign nmy_start = (32'(y_q) >= 32'(HALF)) ? cyh_q[HALF] : '0;

	assign ctr_cls_addr = 32'(cyh_q[0]) * 32'(cw_c) + 32'(cxh_q[0]);
	assign nb_cls_addr  = 32'(nmy_q) * 32'(cw_c) + 32'(nmx_q);
	assign nb_lvl_addr  = ny * 32'(w_c) + nx;

	// One kernel read port: the weight sweep while clearing, else the neighbour weight.
	assign kern_idx = (state_q == ST_CLEAR) ? K_AW'(clr_q) : widx_q;
	assign kern_rd  = (32'(kern_idx) < K_CELLS) ? kern_q[kern_idx] : '0;

	// Centre pixel test and threshold.
	assign cls_hit  = (cls_rd == VALUE_W'(pass_q));
	assign nb_hit   = (cls_rd > VALUE_W'(pass_q));
	assign lvl_c    = $signed(lvl_rd);
	assign lvl_over = lvl_c > LVL_HALF;
	assign err_c    = lvl_over ? lvl_c - LVL_ONE : lvl_c;

	// Share numerator: error times twice the weight.
	assign prod_c = (NUM_W'(err_q) * NUM_W'($signed({1'b0, kern_rd}))) <<< 1;

	// Neighbour update with saturation.
	assign sum_c = SUM_W'(lvl_q) + SUM_W'(div_rsp.quot);
	always_comb begin
		if (sum_c > SUM_W'(LVL_MAX)) begin
			sat_c = LVL_MAX;
		end else if (sum_c < SUM_W'(LVL_MIN)) begin
			sat_c = LVL_MIN;
		end else begin
			sat_c = LEVEL_W'(sum_c);
		end
	end

	assign nb_start = (state_q == ST_CHECK) && cls_hit && (wsum_q != '0);
	assign nb_adv   = ((state_q == ST_NBADDR) && !in_frame) ||
	                  ((state_q == ST_NBCHK) && !nb_hit) ||
	                  ((state_q == ST_NBDIV) && div_rsp.done);
	assign nb_end   = nb_adv && kx_last && ky_last;
	assign px_adv   = ((state_q == ST_CHECK) && !nb_start) || nb_end;
	assign run_end  = px_adv && x_last && y_last && pass_last;
	assign clr_done = (state_q == ST_CLEAR) && (clr_q == PIX_AW'(PIX_CELLS - 1));
	assign after_nb = nb_end ? (run_end ? ST_IDLE : ST_CENTER) : ST_NBADDR;

	// Memory ports.
	assign cls_we    = acc && (cmd.op == OP_CLASS) && (a32 < CLS_CELLS);
	assign cls_waddr = a32[CLS_AW-1:0];
	assign cls_re    = (state_q == ST_CENTER) || (state_q == ST_NBADDR);
	assign cls_raddr = (state_q == ST_CENTER) ? ctr_cls_addr[CLS_AW-1:0]
	                                          : nb_cls_addr[CLS_AW-1:0];

	assign lvl_re    = cls_re;
	assign lvl_raddr = (state_q == ST_CENTER) ? pix_q : nb_lvl_addr[PIX_AW-1:0];
	always_comb begin
		lvl_we    = 1'b0;
		lvl_waddr = pix_q;
		lvl_wdata = err_c;
		if (acc && (cmd.op == OP_PIXEL) && (a32 < PIX_CELLS)) begin
			lvl_we    = 1'b1;
			lvl_waddr = a32[PIX_AW-1:0];
			lvl_wdata = {2'b00, cmd.value, 8'h00};
		end else if ((state_q == ST_CHECK) && cls_hit && lvl_over) begin
			lvl_we = 1'b1;
		end else if ((state_q == ST_NBDIV) && div_rsp.done) begin
			lvl_we    = 1'b1;
			lvl_waddr = nat_q;
			lvl_wdata = sat_c;
		end
	end

	assign dot_we    = (state_q == ST_CLEAR) || ((state_q == ST_CHECK) && cls_hit && lvl_over);
	assign dot_waddr = (state_q == ST_CLEAR) ? clr_q : pix_q;
	assign dot_wdata = (state_q != ST_CLEAR);
	assign dot_re    = acc && (cmd.op == OP_READ);
	assign dot_raddr = a32[PIX_AW-1:0];

	ddh_ram #(.DATA_W(VALUE_W), .DEPTH(CLS_CELLS)) u_class (
		.clk(clk), .we(cls_we), .waddr(cls_waddr), .wdata(cmd.value),
		.re(cls_re), .raddr(cls_raddr), .rdata(cls_rd)
	);

	ddh_ram #(.DATA_W(LEVEL_W), .DEPTH(PIX_CELLS)) u_level (
		.clk(clk), .we(lvl_we), .waddr(lvl_waddr), .wdata(lvl_wdata),
		.re(lvl_re), .raddr(lvl_raddr), .rdata(lvl_rd)
	);

	ddh_ram #(.DATA_W(1), .DEPTH(PIX_CELLS)) u_dot (
		.clk(clk), .we(dot_we), .waddr(dot_waddr), .wdata(dot_wdata),
		.re(dot_re), .raddr(dot_raddr), .rdata(dot_rd)
	);

	assign div_req.start = start_q;
	assign div_req.num   = num_q;
	assign div_req.den   = wsum_q;

	ddh_div u_div (
		.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp)
	);

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc && (cmd.op == OP_READ)) begin
					state_d = ST_READ;
				end else if (acc && (cmd.op == OP_PIXEL) && cmd.last) begin
					state_d = ST_CLEAR;
				end
			end
			ST_READ: begin
				if (rsp_ready) begin
					state_d = ST_IDLE;
				end
			end
			ST_CLEAR: begin
				if (clr_done) begin
					state_d = ST_CENTER;
				end
			end
			ST_CENTER: begin
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (nb_start) begin
					state_d = ST_NBADDR;
				end else begin
					state_d = run_end ? ST_IDLE : ST_CENTER;
				end
			end
			ST_NBADDR: begin
				state_d = in_frame ? ST_NBCHK : after_nb;
			end
			ST_NBCHK: begin
				state_d = nb_hit ? ST_NBDIV : after_nb;
			end
			ST_NBDIV: begin
				if (div_rsp.done) begin
					state_d = after_nb;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Sequencer registers and scan counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pass_q    <= '0;
			x_q       <= '0;
			y_q       <= '0;
			pix_q     <= '0;
			kx_q      <= '0;
			ky_q      <= '0;
			nmx_q     <= '0;
			nmy_q     <= '0;
			clr_q     <= '0;
			wsum_q    <= '0;
			dots_ok_q <= 1'b0;
			start_q   <= 1'b0;
			for (int k = 0; k <= HALF; k++) begin
				cxh_q[k] <= '0;
				cyh_q[k] <= '0;
			end
		end else begin
			state_q <= state_d;
			start_q <= (state_q == ST_NBCHK) && nb_hit;

			// Start of a run: clear dots and total the weights.
			if (acc && (cmd.op == OP_PIXEL) && cmd.last) begin
				clr_q  <= '0;
				wsum_q <= '0;
			end
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + PIX_AW'(1);
				if (32'(clr_q) < K_CELLS) begin
					wsum_q <= wsum_q + WT_W'(kern_rd);
				end
			end
			if (clr_done) begin
				dots_ok_q <= 1'b1;
				pass_q    <= '0;
				x_q       <= '0;
				y_q       <= '0;
				pix_q     <= '0;
				for (int k = 0; k <= HALF; k++) begin
					cxh_q[k] <= '0;
					cyh_q[k] <= '0;
				end
			end

			// Advance to the next pixel, row or pass.
			if (px_adv) begin
				if (x_last) begin
					x_q <= '0;
					for (int k = 0; k <= HALF; k++) begin
						cxh_q[k] <= '0;
					end
					if (y_last) begin
						y_q   <= '0;
						pix_q <= '0;
						for (int k = 0; k <= HALF; k++) begin
							cyh_q[k] <= '0;
						end
						pass_q <= pass_q + PASS_W'(1);
					end else begin
						y_q      <= y_q + XW'(1);
						pix_q    <= pix_q + PIX_AW'(1);
						cyh_q[0] <= wrap_inc(cyh_q[0], ch_c);
						for (int k = 1; k <= HALF; k++) begin
							cyh_q[k] <= cyh_q[k-1];
						end
					end
				end else begin
					x_q      <= x_q + XW'(1);
					pix_q    <= pix_q + PIX_AW'(1);
					cxh_q[0] <= wrap_inc(cxh_q[0], cw_c);
					for (int k = 1; k <= HALF; k++) begin
						cxh_q[k] <= cxh_q[k-1];
					end
				end
			end

			// Walk the kernel window in raster order.
			if (nb_start) begin
				kx_q  <= '0;
				ky_q  <= '0;
				nmx_q <= nmx_start;
				nmy_q <= nmy_start;
			end else if (nb_adv && !nb_end) begin
				if (kx_last) begin
					kx_q  <= '0;
					ky_q  <= ky_q + KW'(1);
					nmx_q <= nmx_start;
					if (ny_lo) begin
						nmy_q <= wrap_inc(nmy_q, ch_c);
					end
				end else begin
					kx_q <= kx_q + KW'(1);
					if (nx_lo) begin
						nmx_q <= wrap_inc(nmx_q, cw_c);
					end
				end
			end
		end
	end

	// Datapath registers and the kernel weights.
	always_ff @(posedge clk) begin
		if (state_q == ST_NBADDR) begin
			widx_q <= K_AW'(32'(ky_q) * KERNEL_SIDE + 32'(kx_q));
			nat_q  <= nb_lvl_addr[PIX_AW-1:0];
		end
		if (state_q == ST_CHECK) begin
			err_q <= err_c;
		end
		if (state_q == ST_NBCHK) begin
			lvl_q <= lvl_c;
			num_q <= prod_c;
		end
		if (acc && (cmd.op == OP_WEIGHT) && (a32 < K_CELLS)) begin
			kern_q[a32[K_AW-1:0]] <= cmd.value;
		end
		if (acc && (cmd.op == OP_READ)) begin
			rd_addr_q <= cmd.address;
			rd_inr_q  <= (a32 < PIX_CELLS);
		end
	end

	assign rsp.valid   = (state_q == ST_READ);
	assign rsp.address = rd_addr_q;
	assign rsp.level   = (dots_ok_q && rd_inr_q && dot_rd) ? DOT_ON : DOT_OFF;

endmodule

// ----- hw/rtl/dot_diffusion_halftoner.sv -----
// Class entries, weights and pixels load one per cycle, back to back, while idle. A read-back
// request waits in the read state until the output register takes it; the next request may be
// taken once it has. A run clears all MAX_SIDE*MAX_SIDE dots, one a cycle; each pass takes
// every pixel through the centre and check states, and each window position of a processed
// pixel through the address state, class check in frame and serial divider for a receiving
// neighbour. Reset (arst_n low) clears control state; the registers return to full size.
module dot_diffusion_halftoner import ddh_pkg::*; #(
	parameter int MAX_SIDE       = 256,
	parameter int MAX_CLASS_SIDE = 128,
	parameter int KERNEL_SIDE    = 5,
	parameter int CLASS_COUNT    = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // address [15:0], value [23:16]
	input  logic [1:0]  s_tuser,   // op [1:0]
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // out_address [15:0], out_level [23:16]
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [8:0]  cfg_data
);

	cfg_t cfg_q;
	cmd_t cmd;
	rsp_t rsp;
	logic rsp_ready;
	logic full_q;
	logic [ADDR_W-1:0]  out_addr_q;
	logic [VALUE_W-1:0] out_level_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width  <= 9'd256;
			cfg_q.image_height <= 9'd256;
			cfg_q.class_width  <= 8'd128;
			cfg_q.class_height <= 8'd128;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_IMAGE_WIDTH:  cfg_q.image_width  <= cfg_data;
				CFG_IMAGE_HEIGHT: cfg_q.image_height <= cfg_data;
				CFG_CLASS_WIDTH:  cfg_q.class_width  <= cfg_data[7:0];
				CFG_CLASS_HEIGHT: cfg_q.class_height <= cfg_data[7:0];
			endcase
		end
	end

	assign cmd.op      = op_t'(s_tuser);
	assign cmd.address = s_tdata[15:0];
	assign cmd.value   = s_tdata[23:16];
	assign cmd.last    = s_tlast;

	ddh_ctrl #(
		.MAX_SIDE(MAX_SIDE),
		.MAX_CLASS_SIDE(MAX_CLASS_SIDE),
		.KERNEL_SIDE(KERNEL_SIDE),
		.CLASS_COUNT(CLASS_COUNT)
	) u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.cmd(cmd), .cmd_valid(s_tvalid), .cmd_ready(s_tready),
		.cfg(cfg_q), .rsp(rsp), .rsp_ready(rsp_ready)
	);

	// Output register: takes a result whenever it is empty or being drained.
	assign rsp_ready = !full_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (rsp.valid && rsp_ready) begin
			full_q <= 1'b1;
		end else if (m_tready) begin
			full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp.valid && rsp_ready) begin
			out_addr_q  <= rsp.address;
			out_level_q <= rsp.level;
		end
	end

	assign m_tvalid = full_q;
	assign m_tdata  = {out_level_q, out_addr_q};

`ifndef ASSERT_OFF
	// A read-back request yields a result on the next cycle.
	a_read_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == OP_READ) |=> rsp.valid)
		else $error("read-back request produced no result");

	// A result that cannot be taken stays pending.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp_ready |=> rsp.valid)
		else $error("pending result was dropped");

	// No request is taken while a result is pending.
	a_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !s_tready)
		else $error("request taken while a result is pending");

	// Halftoned levels are either black or white.
	a_level: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[23:16] == DOT_ON) || (m_tdata[23:16] == DOT_OFF))
		else $error("output level is neither black nor white");
`endif

endmodule

// ----- sim/ddh_checker.sv -----
module ddh_checker import ddh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,   // address [15:0], value [23:16]
	input  logic [1:0]  s_tuser,   // op [1:0]
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,   // out_address [15:0], out_level [23:16]
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [8:0]  cfg_data,
	output int          fails,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [ADDR_W-1:0]  addr;
		logic [VALUE_W-1:0] level;
	} readback_t;

	logic [7:0]  class_mem [16384];
	logic [7:0]  weight_mem [25];
	int          level_mem [65536];
	bit          dot_mem [65536];
	logic [8:0]  width_reg, height_reg;
	logic [7:0]  tile_w_reg, tile_h_reg;
	readback_t   readback_q [$];

	function automatic int fit(int v, int hi);
		if (v < 1) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic int tile_class(int x, int y, int cw, int ch);
		return class_mem[(y % ch) * cw + (x % cw)];
	endfunction

	task automatic report(string what);
		$display("mismatch at %0t: %s", $realtime, what);
		fails++;
	endtask

	// Full diffusion run, worked out in zero time when the last pixel is taken.
	task automatic diffuse_frame();
		int w, h, cw, ch, total, pass, x, y, dx, dy, nx, ny, at, err;
		longint num;
		w = fit(width_reg, 256);
		h = fit(height_reg, 256);
		cw = fit(tile_w_reg, 128);
		ch = fit(tile_h_reg, 128);
		for (int i = 0; i < 65536; i++) dot_mem[i] = 0;
		total = 0;
		for (int i = 0; i < 25; i++) total += weight_mem[i];
		for (pass = 0; pass < 256; pass++) begin
			for (y = 0; y < h; y++) begin
				for (x = 0; x < w; x++) begin
					if (tile_class(x, y, cw, ch) != pass) continue;
					at = y * w + x;
					err = level_mem[at];
					if (err > 32640) begin
						err -= 65280;
						dot_mem[at] = 1;
						level_mem[at] = err;
					end
					if (total == 0) continue;
					for (dy = -2; dy <= 2; dy++) begin
						for (dx = -2; dx <= 2; dx++) begin
							ny = y + dy;
							nx = x + dx;
							if (ny < 0 || ny >= h || nx < 0 || nx >= w) continue;
							if (tile_class(nx, ny, cw, ch) <= pass) continue;
							num = longint'(err) * 2 * weight_mem[(dy + 2) * 5 + dx + 2];
							num = level_mem[ny * w + nx] + num / total;
							if (num > 131071) num = 131071;
							if (num < -131072) num = -131072;
							level_mem[ny * w + nx] = int'(num);
						end
					end
				end
			end
		end
	endtask

	// Follow configuration and requests, and compare every read-back.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg <= 9'd256;
			height_reg <= 9'd256;
			tile_w_reg <= 8'd128;
			tile_h_reg <= 8'd128;
			readback_q.delete();
			pending <= 0;
			fails = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_IMAGE_WIDTH: width_reg <= cfg_data;
					CFG_IMAGE_HEIGHT: height_reg <= cfg_data;
					CFG_CLASS_WIDTH: tile_w_reg <= cfg_data[7:0];
					CFG_CLASS_HEIGHT: tile_h_reg <= cfg_data[7:0];
				endcase
			end
			if (s_tvalid && s_tready) begin
				case (op_t'(s_tuser))
					OP_CLASS: if (s_tdata[15:0] < 16384) class_mem[s_tdata[13:0]] = s_tdata[23:16];
					OP_WEIGHT: if (s_tdata[15:0] < 25) weight_mem[s_tdata[4:0]] = s_tdata[23:16];
					OP_PIXEL: begin
						level_mem[s_tdata[15:0]] = int'(s_tdata[23:16]) * 256;
						if (s_tlast) diffuse_frame();
					end
					OP_READ: readback_q.push_back('{s_tdata[15:0],
						dot_mem[s_tdata[15:0]] ? DOT_ON : DOT_OFF});
				endcase
			end
			if (m_tvalid && m_tready) begin
				if (readback_q.size() == 0) begin
					report($sformatf("unexpected read-back %h", m_tdata));
				end else begin
					if (m_tdata[15:0] !== readback_q[0].addr)
						report($sformatf("address %h, wanted %h", m_tdata[15:0],
							readback_q[0].addr));
					if (m_tdata[23:16] !== readback_q[0].level)
						report($sformatf("level %h at %h, wanted %h", m_tdata[23:16],
							readback_q[0].addr, readback_q[0].level));
					void'(readback_q.pop_front());
				end
			end
			pending <= readback_q.size();
		end
	end
endmodule

// ----- sim/tb_dot_diffusion_halftoner.sv -----
module tb_dot_diffusion_halftoner;
	import ddh_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid, s_tready, s_tlast;
	logic [23:0] s_tdata;   // address [15:0], value [23:16]
	logic [1:0]  s_tuser;   // op [1:0]
	logic        m_tvalid, m_tready;
	logic [23:0] m_tdata;   // out_address [15:0], out_level [23:16]
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [8:0]  cfg_data;
	int          fails, pending;
	int          burst_left;
	int          stall_mode, stall_cnt;

	dot_diffusion_halftoner dut (.*);
	ddh_checker checker_i (.*);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	initial begin
		#200000000;
		$display("status: fail");
		$finish;
	end

	// Result side: stall pattern switches between always ready, even and heavy stalls.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_mode <= 0;
			stall_cnt <= 0;
		end else begin
			if (stall_cnt == 0) begin
				stall_mode <= $urandom_range(0, 2);
				stall_cnt <= $urandom_range(20, 300);
			end else begin
				stall_cnt <= stall_cnt - 1;
			end
			case (stall_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				default: m_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	function automatic int fit(int v, int hi);
		if (v < 1) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	// One request, sent in bursts separated by random gaps.
	task automatic send(op_t op, logic [15:0] addr, logic [7:0] value, logic last);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {value, addr};
		s_tuser <= op;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		burst_left--;
	endtask

	// Hold off until every read-back is in and the block has settled.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic cfg_write(cfg_idx_t idx, logic [8:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [7:0] grey();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'd128;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Configure, load a whole frame, run the diffusion and read the dots back.
	// Weight style: 0 small random, 1 all zero, 2 all full.
	task automatic run_frame(int wr, int hr, int cwr, int chr, int weight_style);
		int w, h, cw, ch, n;
		drain();
		cfg_write(CFG_IMAGE_WIDTH, 9'(wr));
		cfg_write(CFG_IMAGE_HEIGHT, 9'(hr));
		cfg_write(CFG_CLASS_WIDTH, 9'(cwr));
		cfg_write(CFG_CLASS_HEIGHT, 9'(chr));
		w = fit(wr, 256);
		h = fit(hr, 256);
		cw = fit(cwr & 8'hFF, 128);
		ch = fit(chr & 8'hFF, 128);
		n = w * h;
		for (int i = 0; i < 25; i++)
			send(OP_WEIGHT, 16'(i), weight_style == 1 ? 8'd0 : weight_style == 2 ? 8'd255 :
				(($urandom_range(0, 9) == 0) ? 8'd255 : 8'($urandom_range(0, 15))),
				1'($urandom_range(0, 1)));
		// Only the part of the tile that falls inside the frame is ever looked up.
		for (int y = 0; y < (h < ch ? h : ch); y++) begin
			for (int x = 0; x < (w < cw ? w : cw); x++) begin
				send(OP_CLASS, 16'(y * cw + x), (x + y == 0) ? 8'd0 :
					(x == 1 && y == 0) ? 8'd255 : 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)));
				if ($urandom_range(0, 9) == 0)
					send(OP_READ, 16'($urandom), 8'($urandom), 1'($urandom_range(0, 1)));
			end
		end
		send(OP_CLASS, 16'($urandom_range(16384, 65535)), 8'($urandom), 1'b0);
		for (int i = 0; i < n; i++)
			send(OP_PIXEL, 16'(i), grey(), i == n - 1);
		if (n <= 64)
			for (int i = 0; i < n; i++)
				send(OP_READ, 16'(i), 8'($urandom), 1'($urandom_range(0, 1)));
		send(OP_READ, 16'(n), 8'd0, 1'b0);
		send(OP_READ, 16'hFFFF, 8'hFF, 1'b1);
		for (int i = 0; i < 10; i++)
			send(OP_READ, 16'($urandom_range(0, n - 1)), 8'($urandom),
				1'($urandom_range(0, 1)));
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = OP_CLASS;
		s_tlast = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_IMAGE_WIDTH;
		cfg_data = '0;
		burst_left = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reads before any run see cleared dots; stray loads at and past the store ends.
		send(OP_READ, 16'h0000, 8'h00, 1'b0);
		send(OP_READ, 16'hFFFF, 8'hFF, 1'b1);
		send(OP_WEIGHT, 16'd25, 8'hFF, 1'b1);
		send(OP_WEIGHT, 16'hFFFF, 8'h00, 1'b0);
		send(OP_CLASS, 16'd16384, 8'hFF, 1'b1);
		send(OP_CLASS, 16'd16383, 8'h07, 1'b0);

		run_frame(4, 4, 2, 2, 0);
		run_frame(8, 8, 3, 5, 1);
		run_frame(0, 0, 0, 0, 0);
		run_frame(7, 9, 128, 128, 0);
		run_frame(3, 8, 1, 8, 2);
		run_frame(511, 0, 255, 0, 0);
		run_frame(6, 5, 4, 3, 0);
		drain();

		if (fails == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule
